FILE: rtl/core/fcc_pkg.sv
// Shared codes, widths and control types for the calculator key engine.
package fcc_pkg;

    localparam int DISPLAY_CHARS_DEF = 22;
    localparam int WORD_W            = 32;
    localparam int BCD_DIGITS        = 10;
    localparam int ERR_TEXT_LEN      = 5;

    localparam logic [3:0] KEY_CLEAR = 4'd0;
    localparam logic [3:0] KEY_BACK  = 4'd1;
    localparam logic [3:0] KEY_SIGN  = 4'd2;
    localparam logic [3:0] KEY_ADD   = 4'd3;
    localparam logic [3:0] KEY_SUB   = 4'd4;
    localparam logic [3:0] KEY_MUL   = 4'd5;
    localparam logic [3:0] KEY_DIV   = 4'd6;
    localparam logic [3:0] KEY_EQ    = 4'd7;
    localparam logic [3:0] KEY_DIGIT = 4'd8;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [2:0] ST_READY    = 3'd0;
    localparam logic [2:0] ST_INPUT    = 3'd1;
    localparam logic [2:0] ST_EDITED   = 3'd2;
    localparam logic [2:0] ST_SIGNED   = 3'd3;
    localparam logic [2:0] ST_OPERATOR = 3'd4;
    localparam logic [2:0] ST_RESULT   = 3'd5;
    localparam logic [2:0] ST_DIVZERO  = 3'd6;

    typedef struct packed {
        logic start;
        logic is_div;
    } arith_ctl_t;

    typedef enum logic [1:0] {
        JOB_SIGN,
        JOB_OPER,
        JOB_EQ,
        JOB_OUT
    } job_t;

    function automatic logic [2:0] key_to_op(input logic [3:0] k);
        logic [2:0] op;
        case (k)
            KEY_ADD: op = OP_ADD;
            KEY_SUB: op = OP_SUB;
            KEY_MUL: op = OP_MUL;
            KEY_DIV: op = OP_DIV;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

FILE: rtl/core/fcc_arith.sv
// Bit-serial 32-bit wrapping multiplier and signed truncating divider.
module fcc_arith (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fcc_pkg::arith_ctl_t         ctl,
    input  logic [fcc_pkg::WORD_W-1:0]  lhs,
    input  logic [fcc_pkg::WORD_W-1:0]  rhs,
    output logic                        done,
    output logic [fcc_pkg::WORD_W-1:0]  result
);
    import fcc_pkg::*;

    localparam int CW = $clog2(WORD_W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic              div_reg, div_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W:0]   acc_reg, acc_next;
    logic [WORD_W:0]   rem_sh;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_sh    = {acc_reg[WORD_W-1:0], a_reg[WORD_W-1]};
        if (ctl.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            div_next = ctl.is_div;
            acc_next = '0;
            neg_next = lhs[WORD_W-1] ^ rhs[WORD_W-1];
            if (ctl.is_div)
            begin
                a_next = lhs[WORD_W-1] ? (WORD_W'(0) - lhs) : lhs;
                b_next = rhs[WORD_W-1] ? (WORD_W'(0) - rhs) : rhs;
            end
            else
            begin
                a_next = lhs;
                b_next = rhs;
            end
        end
        else if (run_reg)
        begin
            if (div_reg)
            begin
                // restoring step: trial subtract, shift quotient bit in
                if (rem_sh >= {1'b0, b_reg})
                begin
                    acc_next = rem_sh - {1'b0, b_reg};
                    a_next   = {a_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh;
                    a_next   = {a_reg[WORD_W-2:0], 1'b0};
                end
            end
            else
            begin
                if (b_reg[0])
                    acc_next = {1'b0, acc_reg[WORD_W-1:0] + a_reg};
                a_next = {a_reg[WORD_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[WORD_W-1:1]};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(WORD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (WORD_W'(0) - a_reg) : a_reg)
                            : acc_reg[WORD_W-1:0];

endmodule

FILE: rtl/core/fcc_b2d.sv
// Serial binary to decimal converter (shift and add-3), one bit per cycle.
module fcc_b2d (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [fcc_pkg::WORD_W-1:0]                value,
    output logic                                      done,
    output logic [fcc_pkg::BCD_DIGITS*4-1:0]          digits,
    output logic [$clog2(fcc_pkg::BCD_DIGITS+1)-1:0]  count
);
    import fcc_pkg::*;

    localparam int CW = $clog2(WORD_W);
    localparam int NW = $clog2(BCD_DIGITS + 1);

    logic                    run_reg, run_next;
    logic                    done_reg, done_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [WORD_W-1:0]       bin_reg, bin_next;
    logic [BCD_DIGITS*4-1:0] bcd_reg, bcd_next;
    logic [BCD_DIGITS*4-1:0] adj;

    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (bcd_reg[k*4 +: 4] >= 4'd5)
                adj[k*4 +: 4] = bcd_reg[k*4 +: 4] + 4'd3;
            else
                adj[k*4 +: 4] = bcd_reg[k*4 +: 4];
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            bin_next = value;
            bcd_next = '0;
        end
        else if (run_reg)
        begin
            bcd_next = {adj[BCD_DIGITS*4-2:0], bin_reg[WORD_W-1]};
            bin_next = {bin_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(WORD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // significant digits, at least one
    always_comb
    begin
        count = NW'(1);
        for (int k = 1; k < BCD_DIGITS; k++)
        begin
            if (bcd_reg[k*4 +: 4] != 4'd0)
                count = NW'(k + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done   = done_reg;
    assign digits = bcd_reg;

endmodule

FILE: rtl/core/four_function_calculator_keys.sv
// Calculator key engine: display store, digit-serial readout and key sequencer.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  key     | in_valid, in_ready, func, digit_value     | in
//  result  | out_valid, out_ready, display_value,      | out
//          | display_length, display_error,            |
//          | status_code, pending_operator,            |
//          | accumulator_value                         |
//
// One key at a time. A key is decoded and the result is read out digit by
// digit; operators and equals add a first readout, the serial multiply or
// divide when one is pending, and the decimal conversion; sign adds a first
// readout and the conversion. Reset clears the display to "0", the total,
// operator, status, error and output valid flag, but not the output data.
// A stalled result is held in the output register; a key may be taken while
// it waits, but its result waits for the register to empty.
module four_function_calculator_keys #(
    parameter int DISPLAY_CHARS = fcc_pkg::DISPLAY_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  func,
    input  logic [3:0]  digit_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] display_value,
    output logic [4:0]  display_length,
    output logic        display_error,
    output logic [2:0]  status_code,
    output logic [2:0]  pending_operator,
    output logic signed [31:0] accumulator_value
);
    import fcc_pkg::*;

    localparam int CHW = $clog2(DISPLAY_CHARS + 1);
    localparam int IW  = $clog2(DISPLAY_CHARS);
    localparam int NW  = $clog2(BCD_DIGITS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_KEY   = 6'b000010,
        S_READ  = 6'b000100,
        S_ARITH = 6'b001000,
        S_CONV  = 6'b010000,
        S_POST  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    job_t              job_reg, job_next;
    logic [3:0]        func_reg, func_next;
    logic [3:0]        dig_reg, dig_next;
    logic [3:0]        store_reg [DISPLAY_CHARS];
    logic [3:0]        store_next [DISPLAY_CHARS];
    logic [CHW-1:0]    chars_reg, chars_next;
    logic              minus_reg, minus_next;
    logic [WORD_W-1:0] total_reg, total_next;
    logic [2:0]        op_reg, op_next;
    logic              new_reg, new_next;
    logic              err_reg, err_next;
    logic [2:0]        status_reg, status_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [WORD_W-1:0] mag_reg, mag_next;
    logic [WORD_W-1:0] val_reg, val_next;
    logic              cneg_reg, cneg_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] o_val_reg, o_val_next;
    logic [4:0]        o_len_reg, o_len_next;
    logic              o_err_reg, o_err_next;
    logic [2:0]        o_st_reg, o_st_next;
    logic [2:0]        o_op_reg, o_op_next;
    logic [WORD_W-1:0] o_acc_reg, o_acc_next;

    arith_ctl_t              actl;
    logic                    a_done;
    logic [WORD_W-1:0]       a_res;
    logic                    c_go;
    logic [WORD_W-1:0]       c_in;
    logic                    c_done;
    logic [BCD_DIGITS*4-1:0] c_digits;
    logic [NW-1:0]           c_count;

    logic [CHW-1:0]    nd;
    logic              rd_last;
    logic [35:0]       mag_mul;
    logic [WORD_W-1:0] mag_sat;
    logic [WORD_W-1:0] rd_val;
    logic [WORD_W-1:0] res_val;
    logic              clr, fin, key_ok;

    fcc_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (actl),
        .lhs    (total_reg),
        .rhs    (rd_val),
        .done   (a_done),
        .result (a_res)
    );

    fcc_b2d u_b2d (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (c_go),
        .value  (c_in[WORD_W-1] ? (WORD_W'(0) - c_in) : c_in),
        .done   (c_done),
        .digits (c_digits),
        .count  (c_count)
    );

    // one decimal digit of the display per cycle, saturating past 2^31
    assign nd      = chars_reg - CHW'(minus_reg);
    assign rd_last = (CHW'(idx_reg) + CHW'(1)) == nd;
    assign mag_mul = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                   + {32'd0, store_reg[idx_reg]};
    assign mag_sat = (mag_mul > 36'h080000000) ? 32'h80000001 : mag_mul[WORD_W-1:0];
    assign rd_val  = minus_reg
                   ? ((mag_sat >= 32'h80000000) ? 32'h80000000 : (WORD_W'(0) - mag_sat))
                   : ((mag_sat > 32'h7FFFFFFF) ? 32'h7FFFFFFF : mag_sat);

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        func_next      = func_reg;
        dig_next       = dig_reg;
        store_next     = store_reg;
        chars_next     = chars_reg;
        minus_next     = minus_reg;
        total_next     = total_reg;
        op_next        = op_reg;
        new_next       = new_reg;
        err_next       = err_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        mag_next       = mag_reg;
        val_next       = val_reg;
        cneg_next      = cneg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_val_next     = o_val_reg;
        o_len_next     = o_len_reg;
        o_err_next     = o_err_reg;
        o_st_next      = o_st_reg;
        o_op_next      = o_op_reg;
        o_acc_next     = o_acc_reg;
        actl           = '0;
        c_go           = 1'b0;
        c_in           = '0;
        res_val        = rd_val;
        clr            = 1'b0;
        fin            = 1'b0;
        key_ok         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    dig_next   = digit_value;
                    state_next = S_KEY;
                end
            end

            S_KEY:
            begin
                key_ok = (func_reg inside {[KEY_BACK:KEY_EQ]})
                      || (func_reg == KEY_DIGIT && dig_reg <= DIGIT_MAX);
                clr = (func_reg == KEY_CLEAR) || (err_reg && key_ok);
                if (clr)
                begin
                    for (int i = 0; i < DISPLAY_CHARS; i++)
                        store_next[i] = 4'd0;
                    chars_next  = CHW'(1);
                    minus_next  = 1'b0;
                    total_next  = '0;
                    op_next     = OP_NONE;
                    new_next    = 1'b1;
                    err_next    = 1'b0;
                    status_next = ST_READY;
                end
                fin = 1'b1;
                case (func_reg)
                    KEY_BACK:
                    begin
                        if (!err_reg && !new_reg)
                        begin
                            if (chars_reg <= CHW'(1) || (chars_reg == CHW'(2) && minus_reg))
                            begin
                                store_next[0] = 4'd0;
                                chars_next    = CHW'(1);
                                minus_next    = 1'b0;
                                new_next      = 1'b1;
                            end
                            else
                            begin
                                chars_next = chars_reg - CHW'(1);
                            end
                            status_next = ST_EDITED;
                        end
                    end
                    KEY_SIGN:
                    begin
                        if (!err_reg)
                        begin
                            fin      = 1'b0;
                            job_next = JOB_SIGN;
                        end
                    end
                    KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV:
                    begin
                        if (!new_next || op_next == OP_NONE)
                        begin
                            fin      = 1'b0;
                            job_next = JOB_OPER;
                        end
                        else
                        begin
                            op_next     = key_to_op(func_reg);
                            status_next = ST_OPERATOR;
                        end
                    end
                    KEY_EQ:
                    begin
                        if (!err_reg)
                        begin
                            if (op_reg == OP_NONE)
                            begin
                                status_next = ST_RESULT;
                            end
                            else
                            begin
                                fin      = 1'b0;
                                job_next = JOB_EQ;
                            end
                        end
                    end
                    KEY_DIGIT:
                    begin
                        if (dig_reg <= DIGIT_MAX)
                        begin
                            if (err_reg || new_reg)
                            begin
                                store_next[0] = dig_reg;
                                chars_next    = CHW'(1);
                                minus_next    = 1'b0;
                                new_next      = 1'b0;
                                status_next   = ST_INPUT;
                            end
                            else if (chars_reg == CHW'(1) && !minus_reg
                                     && store_reg[0] == 4'd0 && dig_reg != 4'd0)
                            begin
                                // lone zero: replace it
                                store_next[0] = dig_reg;
                            end
                            else if (chars_reg < CHW'(DISPLAY_CHARS))
                            begin
                                store_next[IW'(nd)] = dig_reg;
                                chars_next = chars_reg + CHW'(1);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                idx_next = '0;
                mag_next = '0;
                if (fin)
                begin
                    job_next   = JOB_OUT;
                    state_next = err_next ? S_POST : S_READ;
                end
                else
                begin
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                mag_next = mag_sat;
                idx_next = idx_reg + IW'(1);
                if (rd_last)
                begin
                    case (job_reg)
                        JOB_OUT:
                        begin
                            val_next   = rd_val;
                            state_next = S_POST;
                        end
                        JOB_SIGN:
                        begin
                            c_go       = 1'b1;
                            c_in       = WORD_W'(0) - rd_val;
                            cneg_next  = c_in[WORD_W-1];
                            state_next = S_CONV;
                        end
                        default:
                        begin
                            state_next = S_CONV;
                            case (op_reg)
                                OP_ADD: res_val = total_reg + rd_val;
                                OP_SUB: res_val = total_reg - rd_val;
                                default: res_val = rd_val;
                            endcase
                            if (op_reg == OP_MUL)
                            begin
                                actl       = '{start: 1'b1, is_div: 1'b0};
                                state_next = S_ARITH;
                            end
                            else if (op_reg == OP_DIV)
                            begin
                                if (rd_val == '0)
                                begin
                                    // divide by zero: keep total and operator
                                    err_next      = 1'b1;
                                    store_next[0] = 4'd0;
                                    chars_next    = CHW'(1);
                                    minus_next    = 1'b0;
                                    status_next   = ST_DIVZERO;
                                    state_next    = S_POST;
                                end
                                else
                                begin
                                    actl       = '{start: 1'b1, is_div: 1'b1};
                                    state_next = S_ARITH;
                                end
                            end
                            else
                            begin
                                total_next = res_val;
                                c_go       = 1'b1;
                                c_in       = res_val;
                                cneg_next  = res_val[WORD_W-1];
                            end
                        end
                    endcase
                end
            end

            S_ARITH:
            begin
                if (a_done)
                begin
                    total_next = a_res;
                    c_go       = 1'b1;
                    c_in       = a_res;
                    cneg_next  = a_res[WORD_W-1];
                    state_next = S_CONV;
                end
            end

            S_CONV:
            begin
                if (c_done)
                begin
                    for (int i = 0; i < DISPLAY_CHARS; i++)
                    begin
                        for (int k = 0; k < BCD_DIGITS; k++)
                        begin
                            if (i + k + 1 == int'(c_count))
                                store_next[i] = c_digits[k*4 +: 4];
                        end
                    end
                    chars_next = CHW'(c_count) + CHW'(cneg_reg);
                    minus_next = cneg_reg;
                    case (job_reg)
                        JOB_SIGN:
                        begin
                            new_next    = 1'b0;
                            status_next = ST_SIGNED;
                        end
                        JOB_OPER:
                        begin
                            op_next     = key_to_op(func_reg);
                            new_next    = 1'b1;
                            status_next = ST_OPERATOR;
                        end
                        default:
                        begin
                            op_next     = OP_NONE;
                            new_next    = 1'b1;
                            status_next = ST_RESULT;
                        end
                    endcase
                    job_next   = JOB_OUT;
                    idx_next   = '0;
                    mag_next   = '0;
                    state_next = S_READ;
                end
            end

            S_POST:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_val_next     = err_reg ? '0 : val_reg;
                    o_len_next     = err_reg ? 5'(ERR_TEXT_LEN) : 5'(chars_reg);
                    o_err_next     = err_reg;
                    o_st_next      = status_reg;
                    o_op_next      = op_reg;
                    o_acc_next     = total_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < DISPLAY_CHARS; i++)
                store_reg[i] <= 4'd0;
            chars_reg     <= CHW'(1);
            minus_reg     <= 1'b0;
            total_reg     <= '0;
            op_reg        <= OP_NONE;
            new_reg       <= 1'b1;
            err_reg       <= 1'b0;
            status_reg    <= ST_READY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            store_reg     <= store_next;
            chars_reg     <= chars_next;
            minus_reg     <= minus_next;
            total_reg     <= total_next;
            op_reg        <= op_next;
            new_reg       <= new_next;
            err_reg       <= err_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        func_reg  <= func_next;
        dig_reg   <= dig_next;
        idx_reg   <= idx_next;
        mag_reg   <= mag_next;
        val_reg   <= val_next;
        cneg_reg  <= cneg_next;
        o_val_reg <= o_val_next;
        o_len_reg <= o_len_next;
        o_err_reg <= o_err_next;
        o_st_reg  <= o_st_next;
        o_op_reg  <= o_op_next;
        o_acc_reg <= o_acc_next;
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign display_value     = o_val_reg;
    assign display_length    = o_len_reg;
    assign display_error     = o_err_reg;
    assign status_code       = o_st_reg;
    assign pending_operator  = o_op_reg;
    assign accumulator_value = o_acc_reg;

    a_digits_present: assert property (@(posedge clk) disable iff (!rst_n)
        chars_reg > CHW'(minus_reg))
        else $error("display holds no digit");

    a_chars_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chars_reg <= CHW'(DISPLAY_CHARS))
        else $error("display longer than its store");

    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> status_reg == ST_DIVZERO)
        else $error("error flag without divide-by-zero status");

    a_key_decode: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_KEY)
        else $error("accepted key not decoded");

endmodule
